// ===== design/sqf_pkg.sv =====
`default_nettype none
package sqf_pkg;

  // width of the value field on the input channel
  localparam int VALUE_W = 32;

  typedef logic [VALUE_W-1:0] value_t;

endpackage
`default_nettype wire

// ===== design/sqf_in_if.sv =====
`default_nettype none
interface sqf_in_if;
  import sqf_pkg::*;

  logic   valid;
  logic   ready;
  value_t value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);

endinterface
`default_nettype wire

// ===== design/sqf_out_if.sv =====
`default_nettype none
interface sqf_out_if;
  import sqf_pkg::*;

  logic valid;
  logic ready;
  logic is_squarefree_flag;

  modport source (output valid, output is_squarefree_flag, input ready);
  modport sink (input valid, input is_squarefree_flag, output ready);

endinterface
`default_nettype wire

// ===== design/squarefree_trial_division.sv =====
`default_nettype none
// Square-free test by trial division. Each word on item carries an unsigned value (low WIDTH
// bits used); one word on result returns 1 if no prime squared divides it (0 and 1 give 1).
// The factor 2 and then the odd divisors 3, 5, 7, ... are divided out while the divisor does
// not exceed remainder / divisor; a divisor that divides twice ends the test with 0. All
// division runs on one bit-serial restoring divider that retires one quotient bit per cycle.
// Values 0 and 1 skip the divider; otherwise a 32-bit prime needs about 32768 trial
// divisions. One item is tested at a time; a new word is taken while the previous result
// still waits on result.
module squarefree_trial_division #(
  parameter int WIDTH = 32
) (
  input  wire        clk,
  input  wire        rst,
  sqf_in_if.sink     item,
  sqf_out_if.source  result
);
  import sqf_pkg::*;

  // divisor never exceeds sqrt(2^WIDTH) + 2
  localparam int DW = WIDTH / 2 + 1;
  localparam int CW = $clog2(WIDTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_CHK  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]       state;
  logic [WIDTH-1:0] remainder;
  logic [WIDTH-1:0] quot;
  logic [DW-1:0]    part;
  logic [DW-1:0]    trial_divisor;
  logic [CW-1:0]    cnt;
  logic             hit;
  logic             res;
  logic             oval;
  logic             oflag;

  logic [WIDTH-1:0] v_in;
  logic [DW:0]      trial;
  logic             ge;
  logic [DW:0]      diff;
  logic [DW-1:0]    part_next;
  logic [WIDTH-1:0] quot_next;
  logic             past_bound;

  assign v_in = WIDTH'(item.value);

  // one restoring division step: shift in the next dividend bit, subtract if it fits
  assign trial     = {part, quot[WIDTH-1]};
  assign ge        = trial >= {1'b0, trial_divisor};
  assign diff      = trial - {1'b0, trial_divisor};
  assign part_next = ge ? diff[DW-1:0] : trial[DW-1:0];
  assign quot_next = {quot[WIDTH-2:0], ge};

  // loop bound: divisor greater than remainder / divisor
  assign past_bound = {{(WIDTH-DW){1'b0}}, trial_divisor} > quot;

  assign item.ready  = (state == ST_IDLE);
  assign result.valid = oval;
  assign result.is_squarefree_flag = oflag;

  // test sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      oval          <= 1'b0;
      oflag         <= 1'b0;
      hit           <= 1'b0;
      res           <= 1'b0;
      cnt           <= '0;
      remainder     <= '0;
      quot          <= '0;
      part          <= '0;
      trial_divisor <= '0;
    end else begin
      // a finishing test reloads the output register itself
      if (oval && result.ready && state != ST_FIN) begin
        oval <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (item.valid) begin
            if (v_in[WIDTH-1:1] == '0) begin
              res   <= 1'b1;
              state <= ST_FIN;
            end else begin
              remainder     <= v_in;
              quot          <= v_in;
              part          <= '0;
              trial_divisor <= DW'(2);
              hit           <= 1'b0;
              cnt           <= '0;
              state         <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          part <= part_next;
          quot <= quot_next;
          cnt  <= cnt + CW'(1);
          if (cnt == CW'(WIDTH - 1)) begin
            state <= ST_CHK;
          end
        end
        ST_CHK: begin
          part <= '0;
          cnt  <= '0;
          if (!hit && trial_divisor != DW'(2) && past_bound) begin
            res   <= 1'b1;
            state <= ST_FIN;
          end else if (part == '0) begin
            if (hit) begin
              res   <= 1'b0;
              state <= ST_FIN;
            end else begin
              // divides once: keep the quotient and divide again
              hit       <= 1'b1;
              remainder <= quot;
              state     <= ST_DIV;
            end
          end else begin
            // move on to the next divisor
            hit   <= 1'b0;
            quot  <= remainder;
            state <= ST_DIV;
            if (trial_divisor == DW'(2)) begin
              trial_divisor <= DW'(3);
            end else begin
              trial_divisor <= trial_divisor + DW'(2);
            end
          end
        end
        ST_FIN: begin
          if (!oval || result.ready) begin
            oval  <= 1'b1;
            oflag <= res;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // partial remainder stays below the divisor during division
  a_part_below: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (part < trial_divisor))
    else $error("partial remainder not below divisor");

  // divisor is 2 or odd while a test runs
  a_div_odd: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV || state == ST_CHK) |-> (trial_divisor == DW'(2) || trial_divisor[0]))
    else $error("even trial divisor other than 2");

  // a finished test either waits or has its result posted
  a_fin_post: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN) |=> (state == ST_FIN || (oval && oflag == $past(res))))
    else $error("result lost on finish");

endmodule
`default_nettype wire

// ===== tb/squarefree_trial_division_tb.sv =====
`timescale 1ns / 1ps
module squarefree_trial_division_tb;
  import sqf_pkg::*;

  localparam int WIDTH = VALUE_W;
  localparam int N_DIRECTED = 21;
  localparam int RANDOM_ITEMS = 80;
  // longest directed item (a prime near one million) needs about 500 trial divisions
  localparam int IDLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 2 * (WIDTH + 1) + 16;

  typedef struct packed {
    value_t value;
    bit     known;
    bit     flag;
  } stim_row_t;

  // directed words; flag is only typed in where it is obvious
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{32'd0,          1'b1, 1'b1},
    '{32'd1,          1'b1, 1'b1},
    '{32'd2,          1'b0, 1'b0},
    '{32'd3,          1'b0, 1'b0},
    '{32'd4,          1'b1, 1'b0},
    '{32'd6,          1'b0, 1'b0},
    '{32'd8,          1'b0, 1'b0},
    '{32'd9,          1'b0, 1'b0},
    '{32'd15,         1'b0, 1'b0},
    '{32'd25,         1'b0, 1'b0},
    '{32'd30,         1'b0, 1'b0},
    '{32'd49,         1'b0, 1'b0},
    '{32'd63001,      1'b0, 1'b0},
    '{32'd65521,      1'b0, 1'b0},
    '{32'd510510,     1'b0, 1'b0},
    '{32'd1000003,    1'b0, 1'b0},
    '{32'hFFFF_FFFF,  1'b1, 1'b1},
    '{32'h8000_0000,  1'b1, 1'b0},
    '{32'hFFFF_FFFC,  1'b1, 1'b0},
    '{32'hAAAA_AAAA,  1'b0, 1'b0},
    '{32'h5555_5555,  1'b0, 1'b0}
  };

  logic clk;
  logic rst;

  sqf_in_if  item_ch ();
  sqf_out_if result_ch ();

  squarefree_trial_division #(
    .WIDTH(WIDTH)
  ) DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch.sink),
    .result (result_ch.source)
  );

  bit          flag_expect [$];
  int unsigned words_sent;
  int unsigned results_seen;
  int unsigned squarefree_seen;
  int unsigned fail_count;
  int unsigned idle_cycles;
  int unsigned ready_hold;
  int unsigned ready_pick;
  bit          want_flag;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // trial division: strip 2, then odd divisors while div <= rem / div
  function automatic bit squarefree_of(input value_t v);
    logic [WIDTH-1:0] rem;
    logic [WIDTH-1:0] div;
    int unsigned      hits;
    rem = v[WIDTH-1:0];
    if (rem <= 1) return 1'b1;
    div = value_t'(2);
    while (div == value_t'(2) || div <= rem / div) begin
      hits = 0;
      while (rem % div == 0) begin
        hits++;
        if (hits > 1) return 1'b0;
        rem = rem / div;
      end
      div = (div == value_t'(2)) ? value_t'(3) : div + value_t'(2);
    end
    return 1'b1;
  endfunction

  // values shaped so that every test stops after a modest number of divisions
  function automatic value_t random_value();
    int unsigned kind;
    int unsigned bits;
    int unsigned f;
    value_t      v;
    value_t      sq;
    kind = $urandom_range(0, 9);
    if (kind < 4) begin
      // short values, now and then up to 22 bits
      bits = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 22) : $urandom_range(1, 16);
      v = value_t'($urandom) >> (VALUE_W - bits);
    end else if (kind < 6) begin
      // full-range multiple of a small square
      f = $urandom_range(2, 255);
      sq = f * f;
      v = sq * $urandom_range(1, 32'hFFFF_FFFF / sq);
    end else begin
      // product of small factors, mostly filling the word
      v = 1;
      forever begin
        f = $urandom_range(2, 255);
        if (v > 32'hFFFF_FFFF / f || $urandom_range(0, 11) == 0) return v;
        v = v * f;
      end
    end
    return v;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // present one word and hold it until taken
  task automatic push_item(input value_t v, input bit known, input bit flag);
    item_ch.valid <= 1'b1;
    item_ch.value <= v;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    flag_expect.insert(flag_expect.size(), known ? flag : squarefree_of(v));
    words_sent++;
  endtask

  // sender idle time, optionally until every result is back
  task automatic rest_sender(input bit drain);
    int unsigned gap;
    gap = pick_gap();
    if (drain || gap != 0) item_ch.valid <= 1'b0;
    while (drain && flag_expect.size() != 0) @(posedge clk);
    repeat (gap) @(posedge clk);
  endtask

  // result side back-pressure
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      ready_pick = $urandom_range(0, 99);
      if (ready_pick < 45) begin
        result_ch.ready <= 1'b1;
        ready_hold <= $urandom_range(0, 20);
      end else if (ready_pick < 55) begin
        result_ch.ready <= 1'b1;
        ready_hold <= $urandom_range(100, 400);
      end else if (ready_pick < 92) begin
        result_ch.ready <= 1'b0;
        ready_hold <= $urandom_range(0, 3);
      end else begin
        result_ch.ready <= 1'b0;
        ready_hold <= $urandom_range(20, 80);
      end
    end
  end

  // result check and watchdog
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (result_ch.valid && result_ch.ready) begin
        if (flag_expect.size() == 0) begin
          $error("is_squarefree_flag: unexpected word, expected none, actual %0b",
                 result_ch.is_squarefree_flag);
          fail_count++;
        end else begin
          want_flag = flag_expect.pop_front();
          results_seen++;
          if (result_ch.is_squarefree_flag) squarefree_seen++;
          if (result_ch.is_squarefree_flag !== want_flag) begin
            $error("is_squarefree_flag: expected %0b, actual %0b", want_flag,
                   result_ch.is_squarefree_flag);
            fail_count++;
          end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no word moved for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, flag_expect.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst <= 1'b1;
    item_ch.valid <= 1'b0;
    item_ch.value <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed words, then wait for all of them to come back
    for (int i = 0; i < N_DIRECTED; i++) begin
      push_item(directed_rows[i].value, directed_rows[i].known, directed_rows[i].flag);
      rest_sender(i == N_DIRECTED - 1);
    end

    // random words with an occasional full drain
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      push_item(random_value(), 1'b0, 1'b0);
      if (k == RANDOM_ITEMS - 1) begin
        item_ch.valid <= 1'b0;
      end else begin
        rest_sender($urandom_range(0, 14) == 0);
      end
    end

    while (flag_expect.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("sent %0d words (%0d directed, %0d random), checked %0d results",
             words_sent, N_DIRECTED, RANDOM_ITEMS, results_seen);
    $display("%0d square-free, %0d with a squared factor, %0d mismatches",
             squarefree_seen, results_seen - squarefree_seen, fail_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
